// File: src/hsvrgb_pkg.sv
// Shared types and constants for the HSV to RGB pixel converter.
// No dependencies.
package hsvrgb_pkg;

    localparam int FRAC_BITS = 16;
    localparam int FIELD_W   = 16;
    localparam int ONE_W     = FRAC_BITS + 1;
    localparam logic [ONE_W-1:0] FRAC_ONE = ONE_W'(1) << FRAC_BITS;
    localparam int SECTORS   = 6;

    typedef enum logic [2:0] {
        SECTOR_0 = 3'd0,
        SECTOR_1 = 3'd1,
        SECTOR_2 = 3'd2,
        SECTOR_3 = 3'd3,
        SECTOR_4 = 3'd4,
        SECTOR_5 = 3'd5
    } sector_t;

    typedef struct packed {
        logic [FIELD_W-1:0] hue_frac;
        logic [FIELD_W-1:0] sat_frac;
        logic [FIELD_W-1:0] val_frac;
    } hsv_pixel_t;

    typedef struct packed {
        logic [FIELD_W-1:0] red_out;
        logic [FIELD_W-1:0] green_out;
        logic [FIELD_W-1:0] blue_out;
    } rgb_pixel_t;

    // Pipeline control between the handshake logic and the datapath.
    typedef struct packed {
        logic in_valid;
        logic advance;
    } pipe_ctrl_t;

endpackage

// File: src/hsvrgb_datapath.sv
// Four-stage HSV to RGB datapath: sector split, s-products, v-products, routing.
// Depends on hsvrgb_pkg.
module hsvrgb_datapath (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  hsvrgb_pkg::pipe_ctrl_t  ctrl,
    input  hsvrgb_pkg::hsv_pixel_t  in_pixel,
    output logic                    out_valid,
    output hsvrgb_pkg::rgb_pixel_t  out_pixel
);

    localparam int FW  = hsvrgb_pkg::FRAC_BITS;
    localparam int OW  = hsvrgb_pkg::ONE_W;
    localparam int H6W = FW + 3;

    // stage 1: hue * 6 -> sector, fraction
    logic                      v1_reg;
    logic [2:0]                sector1_reg;
    logic [FW-1:0]             f1_reg, s1_reg, val1_reg;
    logic [H6W-1:0]            h6;

    // stage 2: f*s, (1-f)*s, p
    logic                      v2_reg;
    logic [2:0]                sector2_reg;
    logic [FW-1:0]             fs2_reg, fts2_reg, p2_reg, val2_reg;
    logic [2*FW-1:0]           fs_prod;
    logic [OW+FW-1:0]          fts_prod, p_prod;
    logic [OW-1:0]             one_minus_f, one_minus_s;

    // stage 3: q, t
    logic                      v3_reg;
    logic [2:0]                sector3_reg;
    logic [FW-1:0]             q3_reg, t3_reg, p3_reg, val3_reg;
    logic [OW+FW-1:0]          q_prod, t_prod;

    // stage 4: routed output
    logic                      v4_reg;
    hsvrgb_pkg::rgb_pixel_t    rgb4_reg, rgb4_next;

    assign h6 = H6W'(in_pixel.hue_frac) * H6W'(hsvrgb_pkg::SECTORS);

    assign one_minus_f = hsvrgb_pkg::FRAC_ONE - {1'b0, f1_reg};
    assign one_minus_s = hsvrgb_pkg::FRAC_ONE - {1'b0, s1_reg};
    assign fs_prod     = {{FW{1'b0}}, f1_reg} * {{FW{1'b0}}, s1_reg};
    assign fts_prod    = {{OW{1'b0}}, s1_reg} * {{FW{1'b0}}, one_minus_f};
    assign p_prod      = {{OW{1'b0}}, val1_reg} * {{FW{1'b0}}, one_minus_s};

    assign q_prod = {{OW{1'b0}}, val2_reg}
                  * {{FW{1'b0}}, hsvrgb_pkg::FRAC_ONE - {1'b0, fs2_reg}};
    assign t_prod = {{OW{1'b0}}, val2_reg}
                  * {{FW{1'b0}}, hsvrgb_pkg::FRAC_ONE - {1'b0, fts2_reg}};

    always_comb begin
        case (hsvrgb_pkg::sector_t'(sector3_reg))
            hsvrgb_pkg::SECTOR_1: rgb4_next = '{q3_reg,   val3_reg, p3_reg};
            hsvrgb_pkg::SECTOR_2: rgb4_next = '{p3_reg,   val3_reg, t3_reg};
            hsvrgb_pkg::SECTOR_3: rgb4_next = '{p3_reg,   q3_reg,   val3_reg};
            hsvrgb_pkg::SECTOR_4: rgb4_next = '{t3_reg,   p3_reg,   val3_reg};
            hsvrgb_pkg::SECTOR_5: rgb4_next = '{val3_reg, p3_reg,   q3_reg};
            default:              rgb4_next = '{val3_reg, t3_reg,   p3_reg};
        endcase
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (ctrl.advance) begin
            v1_reg <= ctrl.in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (ctrl.advance) begin
            sector1_reg <= h6[H6W-1:FW];
            f1_reg      <= h6[FW-1:0];
            s1_reg      <= in_pixel.sat_frac;
            val1_reg    <= in_pixel.val_frac;

            sector2_reg <= sector1_reg;
            fs2_reg     <= fs_prod[2*FW-1:FW];
            fts2_reg    <= fts_prod[2*FW-1:FW];
            p2_reg      <= p_prod[2*FW-1:FW];
            val2_reg    <= val1_reg;

            sector3_reg <= sector2_reg;
            q3_reg      <= q_prod[2*FW-1:FW];
            t3_reg      <= t_prod[2*FW-1:FW];
            p3_reg      <= p2_reg;
            val3_reg    <= val2_reg;

            rgb4_reg    <= rgb4_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_pixel = rgb4_reg;

endmodule

// File: src/hsv_to_rgb_pixel_convert_top.sv
// HSV to RGB pixel converter: valid/ready wrapper around the datapath.
// Depends on hsvrgb_pkg and hsvrgb_datapath.
// A transfer reaches result valid after passing four register stages, the first
// loaded at the input transfer edge.
// Throughput: one pixel per cycle; the whole pipeline holds while the output
// register is full and m_ready is low.
// Reset: synchronous active-low aresetn clears all stage valid bits.
module hsv_to_rgb_pixel_convert_top (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  hsvrgb_pkg::hsv_pixel_t  s_pixel,
    output logic                    m_valid,
    input  logic                    m_ready,
    output hsvrgb_pkg::rgb_pixel_t  m_pixel
);

    hsvrgb_pkg::pipe_ctrl_t ctrl;
    logic                   advance;

    // pipeline moves when the output slot is empty or being drained
    assign advance       = !m_valid || m_ready;
    assign s_ready       = advance;
    assign ctrl.in_valid = s_valid;
    assign ctrl.advance  = advance;

    hsvrgb_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .in_pixel  (s_pixel),
        .out_valid (m_valid),
        .out_pixel (m_pixel)
    );

endmodule

// File: sim/hsv_to_rgb_pixel_convert_top_tb.sv
// Self-checking testbench for hsv_to_rgb_pixel_convert_top.
// Depends on hsvrgb_pkg and the converter RTL; predicts every RGB pixel in SV and
// checks it against the DUT under random source gaps and sink back-pressure.
module hsv_to_rgb_pixel_convert_top_tb;

    localparam int FW = hsvrgb_pkg::FIELD_W;

    logic                   aclk    = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    hsvrgb_pkg::hsv_pixel_t s_pixel = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    hsvrgb_pkg::rgb_pixel_t m_pixel;

    hsvrgb_pkg::hsv_pixel_t hsv_pending[$];
    hsvrgb_pkg::rgb_pixel_t rgb_expected[$];
    int         loaded_cnt   = 0;
    int         accepted_cnt = 0;
    int         err_cnt      = 0;
    int         src_idle_pct = 0;
    int         sink_stall_pct = 0;
    logic       in_xfer      = 1'b0;

    hsv_to_rgb_pixel_convert_top i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_pixel (s_pixel),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_pixel (m_pixel)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Six-sector HSV to RGB, products floored to Q0.16.
    function automatic hsvrgb_pkg::rgb_pixel_t predict_rgb(hsvrgb_pkg::hsv_pixel_t px);
        logic [63:0]            one, h, s, v, h6, f, p, q, t;
        hsvrgb_pkg::sector_t    sec;
        hsvrgb_pkg::rgb_pixel_t rgb;
        one = 64'(hsvrgb_pkg::FRAC_ONE);
        h   = 64'(px.hue_frac);
        s   = 64'(px.sat_frac);
        v   = 64'(px.val_frac);
        h6  = h * 64'(hsvrgb_pkg::SECTORS);
        sec = hsvrgb_pkg::sector_t'(3'(h6 >> hsvrgb_pkg::FRAC_BITS));
        f   = h6 & (one - 64'd1);
        p   = (v * (one - s)) >> hsvrgb_pkg::FRAC_BITS;
        q   = (v * (one - ((f * s) >> hsvrgb_pkg::FRAC_BITS))) >> hsvrgb_pkg::FRAC_BITS;
        t   = (v * (one - (((one - f) * s) >> hsvrgb_pkg::FRAC_BITS)))
              >> hsvrgb_pkg::FRAC_BITS;
        case (sec)
            hsvrgb_pkg::SECTOR_1: rgb = '{q[FW-1:0], v[FW-1:0], p[FW-1:0]};
            hsvrgb_pkg::SECTOR_2: rgb = '{p[FW-1:0], v[FW-1:0], t[FW-1:0]};
            hsvrgb_pkg::SECTOR_3: rgb = '{p[FW-1:0], q[FW-1:0], v[FW-1:0]};
            hsvrgb_pkg::SECTOR_4: rgb = '{t[FW-1:0], p[FW-1:0], v[FW-1:0]};
            hsvrgb_pkg::SECTOR_5: rgb = '{v[FW-1:0], p[FW-1:0], q[FW-1:0]};
            default:              rgb = '{v[FW-1:0], t[FW-1:0], p[FW-1:0]};
        endcase
        return rgb;
    endfunction

    // Mostly uniform, with a share of corner values and hue sector edges.
    function automatic logic [FW-1:0] rand_field(bit is_hue);
        logic [FW-1:0] corners[8];
        logic [FW-1:0] edges[10];
        corners = '{16'h0000, 16'h0001, 16'hFFFF, 16'hFFFE,
                    16'h8000, 16'h7FFF, 16'h00FF, 16'hFF00};
        edges   = '{16'd10922, 16'd10923, 16'd21845, 16'd21846, 16'd32767,
                    16'd32768, 16'd43690, 16'd43691, 16'd54613, 16'd54614};
        if (is_hue && $urandom_range(99) < 15)
            return edges[$urandom_range(9)];
        if ($urandom_range(99) < 15)
            return corners[$urandom_range(7)];
        return FW'($urandom);
    endfunction

    task automatic load_pixel(logic [FW-1:0] h, logic [FW-1:0] s,
                              logic [FW-1:0] v);
        hsv_pending.push_back('{h, s, v});
        loaded_cnt++;
    endtask

    task automatic run_phase(int n_items, int idle_pct, int stall_pct);
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        repeat (n_items)
            load_pixel(rand_field(1'b1), rand_field(1'b0), rand_field(1'b0));
        while (accepted_cnt != loaded_cnt || rgb_expected.size() != 0)
            @(negedge aclk);
    endtask

    // Source: hold the current transfer until accepted, then maybe idle.
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || in_xfer)) begin
            if (hsv_pending.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                s_valid <= 1'b1;
                s_pixel <= hsv_pending.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        hsvrgb_pkg::rgb_pixel_t exp_px;
        in_xfer <= s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            rgb_expected.push_back(predict_rgb(s_pixel));
            accepted_cnt <= accepted_cnt + 1;
        end
        if (aresetn && m_valid && m_ready) begin
            if (rgb_expected.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_pixel);
                err_cnt++;
            end else begin
                exp_px = rgb_expected.pop_front();
                if (m_pixel.red_out !== exp_px.red_out) begin
                    $display("%0t: red expected %h actual %h",
                             $time, exp_px.red_out, m_pixel.red_out);
                    err_cnt++;
                end
                if (m_pixel.green_out !== exp_px.green_out) begin
                    $display("%0t: green expected %h actual %h",
                             $time, exp_px.green_out, m_pixel.green_out);
                    err_cnt++;
                end
                if (m_pixel.blue_out !== exp_px.blue_out) begin
                    $display("%0t: blue expected %h actual %h",
                             $time, exp_px.blue_out, m_pixel.blue_out);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: hue at zero, full scale and both sides of each sector edge,
        // saturation and value at their extremes, plus mid-scale and alternating-bit mixes.
        load_pixel(16'h0000, 16'hFFFF, 16'hFFFF);
        load_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
        load_pixel(16'd10922, 16'hFFFF, 16'hFFFF);
        load_pixel(16'd10923, 16'hFFFF, 16'hFFFF);
        load_pixel(16'd21845, 16'hFFFF, 16'hFFFF);
        load_pixel(16'd21846, 16'hFFFF, 16'hFFFF);
        load_pixel(16'd32767, 16'hFFFF, 16'hFFFF);
        load_pixel(16'd32768, 16'hFFFF, 16'hFFFF);
        load_pixel(16'd43690, 16'hFFFF, 16'hFFFF);
        load_pixel(16'd43691, 16'hFFFF, 16'hFFFF);
        load_pixel(16'd54613, 16'hFFFF, 16'hFFFF);
        load_pixel(16'd54614, 16'hFFFF, 16'hFFFF);
        load_pixel(16'd5000, 16'h0000, 16'hFFFF);
        load_pixel(16'd40000, 16'h0000, 16'h1234);
        load_pixel(16'd20000, 16'hFFFF, 16'h0000);
        load_pixel(16'hFFFF, 16'h0000, 16'h0000);
        load_pixel(16'd16384, 16'h8000, 16'h8000);
        load_pixel(16'd49152, 16'h0001, 16'hFFFF);
        load_pixel(16'd60000, 16'hFFFE, 16'h0001);
        load_pixel(16'h5555, 16'hAAAA, 16'h5555);
        load_pixel(16'hAAAA, 16'h5555, 16'hAAAA);

        run_phase(175, 0, 0);
        run_phase(175, 82, 0);
        run_phase(175, 0, 82);
        run_phase(175, 20, 20);

        // Drain window: pipeline is 4 deep, anything extra would show up here.
        repeat (20) @(negedge aclk);
        if (err_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #4000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
